@@ src/contact_enter_stay_exit_tracker_macros.svh @@
// Assertion macros used by the contact tracker checker.
`ifndef CONTACT_ENTER_STAY_EXIT_TRACKER_MACROS_SVH
`define CONTACT_ENTER_STAY_EXIT_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CESX_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("contact tracker check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CESX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("contact tracker check failed");

`endif

@@ src/cesx_pkg.sv @@
// Types and constants shared by the contact tracker modules.
package cesx_pkg;

    localparam int ID_W             = 8;
    localparam int EVENT_W          = 3;
    localparam int MAX_CONTACTS_DEF = 16;
    localparam int ID_BITS_DEF      = 8;
    localparam int QUEUE_DEPTH      = 2;

    typedef enum logic [EVENT_W-1:0] {
        EV_ENTER = 3'd0,
        EV_STAY  = 3'd1,
        EV_EXIT  = 3'd2,
        EV_DONE  = 3'd3,
        EV_FULL  = 3'd4
    } cesx_event_t;

    typedef enum logic {
        OP_REPORT    = 1'b0,
        OP_NEW_CYCLE = 1'b1
    } cesx_op_t;

    typedef struct packed {
        cesx_op_t        op;
        logic [ID_W-1:0] id;
    } cesx_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CUR_RD,
        S_CUR_CMP,
        S_REP_DECIDE,
        S_PREV_RD,
        S_PREV_CMP,
        S_EXIT_RD,
        S_EXIT_LATCH,
        S_XCUR_RD,
        S_XCUR_CMP,
        S_EXIT_EMIT,
        S_EXIT_NEXT,
        S_DONE
    } cesx_state_t;

endpackage

@@ src/cesx_front.sv @@
// Command front end: accepts transactions, classifies them and queues them.
module cesx_front #(
    parameter int ID_BITS = cesx_pkg::ID_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      cmd,
    input  logic [cesx_pkg::ID_W-1:0] other_id,
    output logic                      busy,
    input  logic                      pop,
    output logic                      head_valid,
    output cesx_pkg::cesx_item_t      head
);
    import cesx_pkg::*;

    localparam int ID_KEEP = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam logic [ID_W-1:0] ID_MASK = {ID_W{1'b1}} >> (ID_W - ID_KEEP);
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    cesx_item_t        queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    cesx_item_t        in_item;
    logic              push;
    logic              pull;

    // A new-cycle command carries no id, so its id is forced to zero.
    always_comb
    begin
        in_item.op = cmd ? OP_NEW_CYCLE : OP_REPORT;
        in_item.id = cmd ? '0 : (other_id & ID_MASK);
    end

    assign busy       = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = queue_reg[rd_ptr_reg];
    assign push       = start && !busy;
    assign pull       = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pull)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pull})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ src/cesx_back.sv @@
// Execution back end: set memory, membership scans and result register.
module cesx_back #(
    parameter int MAX_CONTACTS = cesx_pkg::MAX_CONTACTS_DEF,
    parameter int ID_BITS      = cesx_pkg::ID_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  cesx_pkg::cesx_item_t         head,
    output logic                         pop,
    output logic                         strobe,
    output logic [cesx_pkg::EVENT_W-1:0] event_res,
    output logic [cesx_pkg::ID_W-1:0]    contact_id,
    output logic                         last
);
    import cesx_pkg::*;

    localparam int ID_KEEP = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int IDX_W   = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
    localparam int CNT_W   = $clog2(MAX_CONTACTS + 1);
    localparam int AW      = IDX_W + 1;

    cesx_state_t        state_reg, state_next;
    cesx_item_t         item_reg, item_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [ID_KEEP-1:0] cand_reg, cand_next;
    logic [CNT_W-1:0]   cur_cnt_reg, cur_cnt_next;
    logic [CNT_W-1:0]   prev_cnt_reg, prev_cnt_next;
    logic               cur_bank_reg, cur_bank_next;
    logic [ID_KEEP-1:0] rdata_reg;
    logic [ID_KEEP-1:0] mem [2**AW];
    logic               strobe_reg, strobe_next;
    cesx_event_t        event_reg, event_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic               last_reg, last_next;

    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic [ID_KEEP-1:0] id_key;
    logic               hit_id;
    logic               hit_cand;
    logic               cur_last;
    logic               prev_last;
    logic               exit_last;
    logic               cur_empty;
    logic               prev_empty;
    logic               cur_full;

    // The two banks swap roles at each new cycle instead of copying.
    assign id_key     = item_reg.id[ID_KEEP-1:0];
    assign hit_id     = (rdata_reg == id_key);
    assign hit_cand   = (rdata_reg == cand_reg);
    assign cur_last   = (CNT_W'(j_reg) == cur_cnt_reg - CNT_W'(1));
    assign prev_last  = (CNT_W'(j_reg) == prev_cnt_reg - CNT_W'(1));
    assign exit_last  = (CNT_W'(i_reg) == prev_cnt_reg - CNT_W'(1));
    assign cur_empty  = (cur_cnt_reg == '0);
    assign prev_empty = (prev_cnt_reg == '0);
    assign cur_full   = (cur_cnt_reg == CNT_W'(MAX_CONTACTS));
    assign wr_addr    = {cur_bank_reg, cur_cnt_reg[IDX_W-1:0]};

    always_comb
    begin
        unique case (state_reg)
            S_PREV_RD: rd_addr = {~cur_bank_reg, j_reg};
            S_EXIT_RD: rd_addr = {~cur_bank_reg, i_reg};
            default:   rd_addr = {cur_bank_reg, j_reg};
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    if (head.op == OP_REPORT)
                    begin
                        state_next = cur_empty ? S_REP_DECIDE : S_CUR_RD;
                    end
                    else
                    begin
                        state_next = prev_empty ? S_DONE : S_EXIT_RD;
                    end
                end
            end
            S_CUR_RD:     state_next = S_CUR_CMP;
            S_CUR_CMP:
            begin
                priority if (hit_id)   state_next = S_IDLE;
                else if (cur_last)     state_next = S_REP_DECIDE;
                else                   state_next = S_CUR_RD;
            end
            S_REP_DECIDE:
            begin
                if (cur_full || prev_empty) state_next = S_IDLE;
                else                        state_next = S_PREV_RD;
            end
            S_PREV_RD:    state_next = S_PREV_CMP;
            S_PREV_CMP:   state_next = (hit_id || prev_last) ? S_IDLE : S_PREV_RD;
            S_EXIT_RD:    state_next = S_EXIT_LATCH;
            S_EXIT_LATCH: state_next = cur_empty ? S_EXIT_EMIT : S_XCUR_RD;
            S_XCUR_RD:    state_next = S_XCUR_CMP;
            S_XCUR_CMP:
            begin
                priority if (hit_cand) state_next = S_EXIT_NEXT;
                else if (cur_last)     state_next = S_EXIT_EMIT;
                else                   state_next = S_XCUR_RD;
            end
            S_EXIT_EMIT:  state_next = S_EXIT_NEXT;
            S_EXIT_NEXT:  state_next = exit_last ? S_DONE : S_EXIT_RD;
            S_DONE:       state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // Datapath and result logic.
    always_comb
    begin
        pop           = 1'b0;
        wr_en         = 1'b0;
        item_next     = item_reg;
        j_next        = j_reg;
        i_next        = i_reg;
        cand_next     = cand_reg;
        cur_cnt_next  = cur_cnt_reg;
        prev_cnt_next = prev_cnt_reg;
        cur_bank_next = cur_bank_reg;
        strobe_next   = 1'b0;
        event_next    = event_reg;
        id_next       = id_reg;
        last_next     = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                pop = head_valid;
                if (head_valid)
                begin
                    item_next = head;
                    j_next    = '0;
                    i_next    = '0;
                end
            end
            S_CUR_CMP:
            begin
                if (!hit_id && !cur_last)
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_REP_DECIDE:
            begin
                j_next = '0;
                if (cur_full)
                begin
                    strobe_next = 1'b1;
                    event_next  = EV_FULL;
                    id_next     = item_reg.id;
                    last_next   = 1'b1;
                end
                else
                begin
                    wr_en        = 1'b1;
                    cur_cnt_next = cur_cnt_reg + 1'b1;
                    if (prev_empty)
                    begin
                        strobe_next = 1'b1;
                        event_next  = EV_ENTER;
                        id_next     = item_reg.id;
                        last_next   = 1'b1;
                    end
                end
            end
            S_PREV_CMP:
            begin
                priority if (hit_id)
                begin
                    strobe_next = 1'b1;
                    event_next  = EV_STAY;
                    id_next     = item_reg.id;
                    last_next   = 1'b1;
                end
                else if (prev_last)
                begin
                    strobe_next = 1'b1;
                    event_next  = EV_ENTER;
                    id_next     = item_reg.id;
                    last_next   = 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_EXIT_LATCH:
            begin
                cand_next = rdata_reg;
                j_next    = '0;
            end
            S_XCUR_CMP:
            begin
                if (!hit_cand && !cur_last)
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_EXIT_EMIT:
            begin
                strobe_next = 1'b1;
                event_next  = EV_EXIT;
                id_next     = ID_W'(cand_reg);
                last_next   = 1'b0;
            end
            S_EXIT_NEXT:
            begin
                i_next = i_reg + 1'b1;
            end
            S_DONE:
            begin
                strobe_next   = 1'b1;
                event_next    = EV_DONE;
                id_next       = '0;
                last_next     = 1'b1;
                cur_bank_next = ~cur_bank_reg;
                prev_cnt_next = cur_cnt_reg;
                cur_cnt_next  = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cur_cnt_reg  <= '0;
            prev_cnt_reg <= '0;
            cur_bank_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_cnt_reg  <= cur_cnt_next;
            prev_cnt_reg <= prev_cnt_next;
            cur_bank_reg <= cur_bank_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        j_reg     <= j_next;
        i_reg     <= i_next;
        cand_reg  <= cand_next;
        event_reg <= event_next;
        id_reg    <= id_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= id_key;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign strobe     = strobe_reg;
    assign event_res  = event_reg;
    assign contact_id = id_reg;
    assign last       = last_reg;

endmodule

@@ src/contact_enter_stay_exit_tracker.sv @@
// Report: scans the C current entries, then the P previous entries, at most once each.
// New cycle: scans the current set per previous entry; exits, then cycle done, leave singly.
// Each result leaves a register in the cycle after its decision; one transaction at a time.
// Scans are paced by the single read port of the set memory, one entry at a time.
// Reset clears both counts, the bank select and the two-entry command queue.
// Stored ids are not reset; only entries below a count are ever read.
module contact_enter_stay_exit_tracker #(
    parameter int MAX_CONTACTS = cesx_pkg::MAX_CONTACTS_DEF,
    parameter int ID_BITS      = cesx_pkg::ID_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         cmd,
    input  logic [cesx_pkg::ID_W-1:0]    other_id,
    output logic                         strobe,
    output logic [cesx_pkg::EVENT_W-1:0] event_res,
    output logic [cesx_pkg::ID_W-1:0]    contact_id,
    output logic                         last
);
    import cesx_pkg::*;

    // The front end takes a transaction whenever its queue has room, masks
    // the id to the configured id width and decodes the command. The back
    // end pulls one queued transaction at a time and runs it to the end.
    cesx_item_t head;
    logic       head_valid;
    logic       pop;

    cesx_front #(
        .ID_BITS (ID_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .other_id   (other_id),
        .busy       (busy),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // The back end holds both contact sets in one memory split into two
    // banks. A new cycle flips which bank is current, so the previous set
    // is never copied. Membership is found by scanning a set entry by entry.
    cesx_back #(
        .MAX_CONTACTS (MAX_CONTACTS),
        .ID_BITS      (ID_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .strobe     (strobe),
        .event_res  (event_res),
        .contact_id (contact_id),
        .last       (last)
    );

endmodule

@@ src/cesx_checker.sv @@
// Port-level checker for the contact tracker and its bind statement.
`include "contact_enter_stay_exit_tracker_macros.svh"

module cesx_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         strobe,
    input logic [cesx_pkg::EVENT_W-1:0] event_res,
    input logic [cesx_pkg::ID_W-1:0]    contact_id,
    input logic                         last
);
    import cesx_pkg::*;

    // Only the five defined event codes may leave the block.
    `CESX_ASSERT_NOW(a_event_legal, strobe, event_res <= EV_FULL)
    // A cycle-done result closes its transaction and carries no id.
    `CESX_ASSERT_NOW(a_done_shape, strobe && (event_res == EV_DONE), last && (contact_id == '0))
    // An exit is never the final result of a new-cycle transaction.
    `CESX_ASSERT_NOW(a_exit_not_last, strobe && (event_res == EV_EXIT), !last)
    // An exit is never directly followed by a final enter, stay or full result.
    `CESX_ASSERT_NEXT(a_exit_followed, strobe && (event_res == EV_EXIT), !(strobe && last && (event_res == EV_ENTER || event_res == EV_STAY || event_res == EV_FULL)))

endmodule

bind contact_enter_stay_exit_tracker cesx_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .strobe     (strobe),
    .event_res  (event_res),
    .contact_id (contact_id),
    .last       (last)
);
